FILE: sv/expiry_list_with_branch_mask_assert.svh
// assertion macros shared by the expiry list modules
`ifndef EXPIRY_LIST_WITH_BRANCH_MASK_ASSERT_SVH
`define EXPIRY_LIST_WITH_BRANCH_MASK_ASSERT_SVH
`ifndef ASSERT_OFF
`define AST_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("invariant violated");
`define AST_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sequence violated");
`else
`define AST_ALWAYS(lbl, clk, rst, expr)
`define AST_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

FILE: sv/elbm_pkg.sv
`default_nettype none
package elbm_pkg;

   localparam int NODES      = 32;
   localparam int NODE_W     = 5;
   localparam int IDX_W      = $clog2(NODES);
   localparam int LINK_W     = $clog2(NODES + 1);
   localparam int EXP_W      = 32;
   localparam int BR_W       = 8;
   localparam int KIND_W     = 2;
   localparam int OP_W       = 2;
   localparam int MASK_W     = 64;
   localparam int MASK_WORDS = 4;
   localparam int MIDX_W     = 2;
   localparam int MASK_BITS  = MASK_W * MASK_WORDS;
   localparam int DATA_W     = EXP_W + BR_W;

   localparam logic [LINK_W-1:0] NIL = LINK_W'(NODES);

   typedef enum logic [OP_W-1:0] {
      OP_APPEND = 2'd0,
      OP_REMOVE = 2'd1,
      OP_UPDATE = 2'd2,
      OP_CHECK  = 2'd3
   } op_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_ACK  = 2'd0,
      KIND_NODE = 2'd1,
      KIND_MASK = 2'd2
   } kind_type;

   typedef struct packed {
      logic load;
      logic rd_head;
      logic unlink;
      logic link_a;
      logic link_b;
      logic emit_ack;
      logic ack_err;
      logic emit_node;
      logic emit_mask;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   op_ok;
      logic   head_nil;
      logic   expired;
      logic   mask_last;
   } sts_type;

endpackage
`default_nettype wire

FILE: sv/elbm_ram.sv
`default_nettype none
module elbm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

FILE: sv/elbm_ctrl.sv
`default_nettype none
`include "expiry_list_with_branch_mask_assert.svh"
module elbm_ctrl import elbm_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   input  wire sts_type sts,
   output logic         busy,
   output cmd_type      cmd
);

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_DECIDE = 8'b0000_0010,
      ST_UNLINK = 8'b0000_0100,
      ST_LINK_A = 8'b0000_1000,
      ST_LINK_B = 8'b0001_0000,
      ST_RDHEAD = 8'b0010_0000,
      ST_EVAL   = 8'b0100_0000,
      ST_MASK   = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   assign busy = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (sts.op == OP_CHECK) begin
               cmd.rd_head = 1'b1;
               state_in    = sts.head_nil ? ST_MASK : ST_EVAL;
            end else if (!sts.op_ok) begin
               cmd.emit_ack = 1'b1;
               cmd.ack_err  = 1'b1;
               state_in     = ST_IDLE;
            end else if (sts.op == OP_APPEND) begin
               state_in = ST_LINK_A;
            end else begin
               state_in = ST_UNLINK;
            end
         end
         ST_UNLINK: begin
            cmd.unlink = 1'b1;
            if (sts.op == OP_REMOVE) begin
               cmd.emit_ack = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_LINK_A;
            end
         end
         ST_LINK_A: begin
            cmd.link_a = 1'b1;
            state_in   = ST_LINK_B;
         end
         ST_LINK_B: begin
            cmd.link_b   = 1'b1;
            cmd.emit_ack = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_RDHEAD: begin
            cmd.rd_head = 1'b1;
            state_in    = sts.head_nil ? ST_MASK : ST_EVAL;
         end
         ST_EVAL: begin
            if (sts.expired) begin
               cmd.unlink    = 1'b1;
               cmd.emit_node = 1'b1;
               state_in      = ST_RDHEAD;
            end else begin
               state_in = ST_MASK;
            end
         end
         ST_MASK: begin
            cmd.emit_mask = 1'b1;
            if (sts.mask_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `AST_NEXT(a_start_goes_busy, clock, reset, start && !busy, busy)
   `AST_NEXT(a_mask_end_idle, clock, reset, state_ff == ST_MASK && sts.mask_last, !busy)

endmodule
`default_nettype wire

FILE: sv/elbm_dp.sv
`default_nettype none
`include "expiry_list_with_branch_mask_assert.svh"
module elbm_dp import elbm_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [OP_W-1:0]   req_op,
   input  wire logic [NODE_W-1:0] req_node,
   input  wire logic [EXP_W-1:0]  req_expires,
   input  wire logic [BR_W-1:0]   req_branch,
   input  wire logic [EXP_W-1:0]  req_now,
   input  wire cmd_type           cmd,
   output sts_type                sts,
   output logic                   rsp_valid,
   output logic [KIND_W-1:0]      rsp_kind,
   output logic [NODE_W-1:0]      rsp_expired_node,
   output logic [BR_W-1:0]        rsp_expired_branch,
   output logic [MIDX_W-1:0]      rsp_mask_index,
   output logic [MASK_W-1:0]      rsp_mask_word,
   output logic                   rsp_error,
   output logic                   rsp_last
);

   op_type              op_ff;
   logic [NODE_W-1:0]   node_ff;
   logic [EXP_W-1:0]    exp_ff;
   logic [BR_W-1:0]     br_ff;
   logic [EXP_W-1:0]    now_ff;
   logic [LINK_W-1:0]   head_ff, head_in;
   logic [LINK_W-1:0]   tail_ff, tail_in;
   logic [NODES-1:0]    linked_ff, linked_in;
   logic [MASK_BITS-1:0] mask_ff;
   logic [MIDX_W-1:0]   midx_ff;

   logic                rsp_valid_ff;
   logic [KIND_W-1:0]   rsp_kind_ff;
   logic [NODE_W-1:0]   rsp_node_ff;
   logic [BR_W-1:0]     rsp_branch_ff;
   logic [MIDX_W-1:0]   rsp_midx_ff;
   logic [MASK_W-1:0]   rsp_word_ff;
   logic                rsp_error_ff;
   logic                rsp_last_ff;

   logic [IDX_W-1:0]    node_idx;
   logic [IDX_W-1:0]    head_idx;
   logic [IDX_W-1:0]    target_idx;
   logic [LINK_W-1:0]   node_link;
   logic [IDX_W-1:0]    rd_addr;
   logic [LINK_W-1:0]   next_rd, prev_rd;
   logic [DATA_W-1:0]   data_rd;
   logic [EXP_W-1:0]    exp_rd;
   logic [BR_W-1:0]     br_rd;

   logic                next_we, prev_we;
   logic [IDX_W-1:0]    next_wa, prev_wa;
   logic [LINK_W-1:0]   next_wd, prev_wd;

   assign node_idx   = node_ff[IDX_W-1:0];
   assign head_idx   = head_ff[IDX_W-1:0];
   assign node_link  = LINK_W'(node_ff);
   assign target_idx = (op_ff == OP_CHECK) ? head_idx : node_idx;
   assign rd_addr    = cmd.rd_head ? head_idx : node_idx;
   assign exp_rd     = data_rd[DATA_W-1:BR_W];
   assign br_rd      = data_rd[BR_W-1:0];

   elbm_ram #(.WIDTH(LINK_W), .DEPTH(NODES)) u_next_ram (
      .clock   (clock),
      .wr_en   (next_we),
      .wr_addr (next_wa),
      .wr_data (next_wd),
      .rd_addr (rd_addr),
      .rd_data (next_rd)
   );

   elbm_ram #(.WIDTH(LINK_W), .DEPTH(NODES)) u_prev_ram (
      .clock   (clock),
      .wr_en   (prev_we),
      .wr_addr (prev_wa),
      .wr_data (prev_wd),
      .rd_addr (rd_addr),
      .rd_data (prev_rd)
   );

   elbm_ram #(.WIDTH(DATA_W), .DEPTH(NODES)) u_data_ram (
      .clock   (clock),
      .wr_en   (cmd.link_a),
      .wr_addr (node_idx),
      .wr_data ({exp_ff, br_ff}),
      .rd_addr (rd_addr),
      .rd_data (data_rd)
   );

   // link edits
   always_comb begin
      next_we   = 1'b0;
      next_wa   = node_idx;
      next_wd   = NIL;
      prev_we   = 1'b0;
      prev_wa   = node_idx;
      prev_wd   = tail_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      linked_in = linked_ff;
      if (cmd.unlink) begin
         if (prev_rd == NIL) begin
            head_in = next_rd;
         end else begin
            next_we = 1'b1;
            next_wa = prev_rd[IDX_W-1:0];
            next_wd = next_rd;
         end
         if (next_rd == NIL) begin
            tail_in = prev_rd;
         end else begin
            prev_we = 1'b1;
            prev_wa = next_rd[IDX_W-1:0];
            prev_wd = prev_rd;
         end
         linked_in[target_idx] = 1'b0;
      end
      if (cmd.link_a) begin
         next_we = 1'b1;
         prev_we = 1'b1;
      end
      if (cmd.link_b) begin
         if (tail_ff == NIL) begin
            head_in = node_link;
         end else begin
            next_we = 1'b1;
            next_wa = tail_ff[IDX_W-1:0];
            next_wd = node_link;
         end
         tail_in             = node_link;
         linked_in[node_idx] = 1'b1;
      end
   end

   always_comb begin
      sts.op        = op_ff;
      sts.op_ok     = (node_link < NIL) &&
                      ((op_ff == OP_APPEND) ? !linked_ff[node_idx] : linked_ff[node_idx]);
      sts.head_nil  = (head_ff == NIL);
      sts.expired   = (exp_rd <= now_ff);
      sts.mask_last = (midx_ff == MIDX_W'(MASK_WORDS - 1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff   <= NIL;
         tail_ff   <= NIL;
         linked_ff <= '0;
         midx_ff   <= '0;
      end else begin
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         linked_ff <= linked_in;
         if (cmd.load) begin
            midx_ff <= '0;
         end else if (cmd.emit_mask) begin
            midx_ff <= midx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= op_type'(req_op);
         node_ff <= req_node;
         exp_ff  <= req_expires;
         br_ff   <= req_branch;
         now_ff  <= req_now;
         mask_ff <= '0;
      end else if (cmd.emit_node) begin
         mask_ff[br_rd] <= 1'b1;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.emit_ack | cmd.emit_node | cmd.emit_mask;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_ack | cmd.emit_node | cmd.emit_mask) begin
         rsp_kind_ff   <= KIND_ACK;
         rsp_node_ff   <= '0;
         rsp_branch_ff <= '0;
         rsp_midx_ff   <= '0;
         rsp_word_ff   <= '0;
         rsp_error_ff  <= 1'b0;
         rsp_last_ff   <= 1'b0;
         if (cmd.emit_ack) begin
            rsp_error_ff <= cmd.ack_err;
            rsp_last_ff  <= 1'b1;
         end
         if (cmd.emit_node) begin
            rsp_kind_ff   <= KIND_NODE;
            rsp_node_ff   <= NODE_W'(head_ff);
            rsp_branch_ff <= br_rd;
         end
         if (cmd.emit_mask) begin
            rsp_kind_ff <= KIND_MASK;
            rsp_midx_ff <= midx_ff;
            rsp_word_ff <= mask_ff[midx_ff*MASK_W +: MASK_W];
            rsp_last_ff <= sts.mask_last;
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = rsp_kind_ff;
   assign rsp_expired_node   = rsp_node_ff;
   assign rsp_expired_branch = rsp_branch_ff;
   assign rsp_mask_index     = rsp_midx_ff;
   assign rsp_mask_word      = rsp_word_ff;
   assign rsp_error          = rsp_error_ff;
   assign rsp_last           = rsp_last_ff;

   `AST_ALWAYS(a_head_tail_empty, clock, reset, (head_ff == NIL) == (tail_ff == NIL))
   `AST_ALWAYS(a_empty_no_linked, clock, reset, (head_ff != NIL) || (linked_ff == '0))

endmodule
`default_nettype wire

FILE: sv/expiry_list_with_branch_mask.sv
`default_nettype none
// Timer expiry list over 32 node slots. A transaction is taken when start is high and busy
// low; busy then stays high up to the clock edge that registers its last result. Results
// appear on the rsp_ ports for a single cycle each, flagged by rsp_valid, and the receiver
// cannot stall them, so they must be captured as they come. After the accepting edge,
// append steps through decide, link_a and link_b; remove through decide and unlink;
// update through decide, unlink, link_a and link_b; a refused op ends with an error ack.
// Pointer edits use link memories with registered reads. For each expired node, check does
// a registered read of the head, then the unlink; the walk ends on an empty list or an
// unexpired node, then the four mask words follow. Every last result has rsp_last set.
module expiry_list_with_branch_mask import elbm_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire logic [OP_W-1:0]   req_op,
   input  wire logic [NODE_W-1:0] req_node,
   input  wire logic [EXP_W-1:0]  req_expires,
   input  wire logic [BR_W-1:0]   req_branch,
   input  wire logic [EXP_W-1:0]  req_now,
   output logic                   rsp_valid,
   output logic [KIND_W-1:0]      rsp_kind,
   output logic [NODE_W-1:0]      rsp_expired_node,
   output logic [BR_W-1:0]        rsp_expired_branch,
   output logic [MIDX_W-1:0]      rsp_mask_index,
   output logic [MASK_W-1:0]      rsp_mask_word,
   output logic                   rsp_error,
   output logic                   rsp_last
);

   cmd_type cmd;
   sts_type sts;

   elbm_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .sts   (sts),
      .busy  (busy),
      .cmd   (cmd)
   );

   elbm_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .req_op             (req_op),
      .req_node           (req_node),
      .req_expires        (req_expires),
      .req_branch         (req_branch),
      .req_now            (req_now),
      .cmd                (cmd),
      .sts                (sts),
      .rsp_valid          (rsp_valid),
      .rsp_kind           (rsp_kind),
      .rsp_expired_node   (rsp_expired_node),
      .rsp_expired_branch (rsp_expired_branch),
      .rsp_mask_index     (rsp_mask_index),
      .rsp_mask_word      (rsp_mask_word),
      .rsp_error          (rsp_error),
      .rsp_last           (rsp_last)
   );

endmodule
`default_nettype wire
